[rtl/vlpf_pkg.sv]
`timescale 1ns / 1ps

package vlpf_pkg;

    // grid limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_REACH  = 4;
    localparam int COUNT_BITS = 16;

    // line buffer: one bank per buffered row, power-of-two bank count
    localparam int SLOTS     = 2 * MAX_REACH;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int DIST_BITS = $clog2(SLOTS + 1);

    // position fields
    localparam int ROW_BITS = 6;
    localparam int COL_BITS = 6;

    // register fields
    localparam int DIM_BITS    = 7;
    localparam int REACH_BITS  = 3;
    localparam int MARGIN_BITS = 16;

    localparam logic [DIM_BITS-1:0]    RST_GRID_COLS    = 7'd40;
    localparam logic [DIM_BITS-1:0]    RST_GRID_ROWS    = 7'd50;
    localparam logic [REACH_BITS-1:0]  RST_WINDOW_REACH = 3'd3;
    localparam logic [MARGIN_BITS-1:0] RST_SLOPE_MARGIN = 16'd10;

    // apb
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        REG_GRID_COLS,
        REG_GRID_ROWS,
        REG_WINDOW_REACH,
        REG_SLOPE_MARGIN
    } t_reg_idx;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [REACH_BITS-1:0] clamp_reach(input logic [REACH_BITS-1:0] v);
        logic [REACH_BITS-1:0] r;
        if (v == '0) begin
            r = REACH_BITS'(1);
        end else if (v > REACH_BITS'(MAX_REACH)) begin
            r = REACH_BITS'(MAX_REACH);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/vlpf_if.sv]
`timescale 1ns / 1ps

interface vlpf_in_if;
    import vlpf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] cell_count;
    logic                  frame_start;

    modport source (output valid, output cell_count, output frame_start, input ready);
    modport sink   (input valid, input cell_count, input frame_start, output ready);
endinterface

interface vlpf_out_if;
    import vlpf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROW_BITS-1:0]   out_row;
    logic [COL_BITS-1:0]   out_col;
    logic [COUNT_BITS-1:0] out_count;
    logic                  last_of_run;

    modport source (output valid, output out_row, output out_col, output out_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_count,
                    input last_of_run, output ready);
endinterface

[rtl/vertical_local_peak_filter.sv]
`timescale 1ns / 1ps

// vertical local peak filter
// i_cell takes one grid count per transaction in raster order, rows first;
// frame_start marks row 0, column 0 of a new frame. o_res gives the decided
// cells with their row and column; last_of_run flags the final result that
// one input transaction causes (at most two: an inner-row decision first,
// then a bottom border pass-through). Border rows pass unchanged at once;
// an inner cell is decided when the cell window_reach rows below it arrives.
// A result passes the input register, then the output register, before it is
// offered; the second result of a pair follows the first from the same input
// register. Throughput: one cell per cycle while o_res takes results; an input
// with two results holds i_cell until its second enters the output register.
// The line buffer is one 64-entry bank per buffered row, all read at the
// column together. Reset clears position, pipeline and registers to their
// defaults; buffer contents are undefined until written. When o_res stalls
// the output register holds and the pipeline stops behind it. Registers (apb,
// 4-byte stride): column count, row count, window_reach, slope_margin; the
// user writes them only while the block is idle, which it does not enforce.

module vertical_local_peak_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    vlpf_in_if.sink                              i_cell,
    vlpf_out_if.source                           o_res,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vlpf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [vlpf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [vlpf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import vlpf_pkg::*;

    // configuration registers
    logic [DIM_BITS-1:0]    r_grid_cols;
    logic [DIM_BITS-1:0]    r_grid_rows;
    logic [REACH_BITS-1:0]  r_window_reach;
    logic [MARGIN_BITS-1:0] r_slope_margin;
    logic                   cfg_wr;
    t_reg_idx               cfg_idx;

    // effective geometry
    logic [DIM_BITS-1:0]    w_eff;
    logic [DIM_BITS-1:0]    h_eff;
    logic [REACH_BITS-1:0]  rch;

    // raster position
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic [COL_BITS-1:0]    r_col, n_col;
    logic [ROW_BITS-1:0]    cur_row;
    logic [COL_BITS-1:0]    cur_col;
    logic [COL_BITS:0]      col_inc;
    logic [ROW_BITS:0]      row_inc;
    logic                   in_acc;

    // registered read data of the line buffer banks
    t_count                 r_rd   [SLOTS];

    // decision stage
    logic                   r_s1_valid, n_s1_valid;
    logic                   r_s1_phase, n_s1_phase;
    logic [ROW_BITS-1:0]    r_s1_row;
    logic [COL_BITS-1:0]    r_s1_col;
    t_count                 r_s1_cnt;
    logic [ROW_BITS-1:0]    r0;
    t_count                 center;
    logic                   keep;
    logic                   has_a, has_b, any_res, two_left, sel_a;
    logic                   s1_emit, s1_pop;
    logic [ROW_BITS+1:0]    row_ext;

    // output register
    logic                   r_o_valid;
    logic [ROW_BITS-1:0]    r_o_row;
    logic [COL_BITS-1:0]    r_o_col;
    t_count                 r_o_count;
    logic                   r_o_last;
    logic                   out_ok;

    // ------------------------------------------------------------------
    // apb register file, zero wait states
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols    <= RST_GRID_COLS;
            r_grid_rows    <= RST_GRID_ROWS;
            r_window_reach <= RST_WINDOW_REACH;
            r_slope_margin <= RST_SLOPE_MARGIN;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GRID_COLS:    r_grid_cols    <= pwdata[DIM_BITS-1:0];
                REG_GRID_ROWS:    r_grid_rows    <= pwdata[DIM_BITS-1:0];
                REG_WINDOW_REACH: r_window_reach <= pwdata[REACH_BITS-1:0];
                REG_SLOPE_MARGIN: r_slope_margin <= pwdata[MARGIN_BITS-1:0];
                default:          r_slope_margin <= r_slope_margin;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GRID_COLS:    prdata = APB_DATA_BITS'(r_grid_cols);
            REG_GRID_ROWS:    prdata = APB_DATA_BITS'(r_grid_rows);
            REG_WINDOW_REACH: prdata = APB_DATA_BITS'(r_window_reach);
            REG_SLOPE_MARGIN: prdata = APB_DATA_BITS'(r_slope_margin);
            default:          prdata = '0;
        endcase
    end

    assign w_eff = clamp_dim(r_grid_cols, DIM_BITS'(MAX_WIDTH));
    assign h_eff = clamp_dim(r_grid_rows, DIM_BITS'(MAX_HEIGHT));
    assign rch   = clamp_reach(r_window_reach);

    // ------------------------------------------------------------------
    // input side: position tracking and line buffer access
    // ------------------------------------------------------------------
    assign in_acc  = i_cell.valid & i_cell.ready;
    assign cur_row = i_cell.frame_start ? '0 : r_row;
    assign cur_col = i_cell.frame_start ? '0 : r_col;
    assign col_inc = {1'b0, cur_col} + 1'b1;
    assign row_inc = {1'b0, cur_row} + 1'b1;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (in_acc) begin
            if (DIM_BITS'(col_inc) >= w_eff) begin
                // end of row, wrap to the next one and past the last row to the top
                n_col = '0;
                n_row = (DIM_BITS'(row_inc) >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
            end else begin
                n_col = col_inc[COL_BITS-1:0];
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // all banks read at the column; the bank of the current row is read
    // before it is overwritten, which is the row eight back when reach is 4
    for (genvar s = 0; s < SLOTS; s++) begin : g_bank
        t_count r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (in_acc) begin
                r_rd[s] <= r_mem[cur_col];
                if (cur_row[SLOT_BITS-1:0] == SLOT_BITS'(s)) begin
                    r_mem[cur_col] <= i_cell.cell_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row <= cur_row;
            r_s1_col <= cur_col;
            r_s1_cnt <= i_cell.cell_count;
        end
    end

    // ------------------------------------------------------------------
    // decision stage
    // ------------------------------------------------------------------
    assign row_ext = (ROW_BITS+2)'(r_s1_row);
    // inner decision for the row reach rows up
    assign has_a = (row_ext >= (ROW_BITS+2)'({rch, 1'b0}))
                && (row_ext < (ROW_BITS+2)'(h_eff));
    // border row passes at once (covers short frames too)
    assign has_b = (row_ext < (ROW_BITS+2)'(rch))
                || ((row_ext + (ROW_BITS+2)'(rch)) >= (ROW_BITS+2)'(h_eff));

    assign r0     = r_s1_row - ROW_BITS'(rch);
    assign center = r_rd[r0[SLOT_BITS-1:0]];

    // each bank is classified by its distance back from the current row;
    // distance zero is the current row's own bank, i.e. one full ring back
    always_comb begin
        logic [SLOT_BITS-1:0] d;
        logic [DIST_BITS-1:0] lag;
        keep = (center != '0)
            && ({1'b0, center} >= ({1'b0, r_s1_cnt} + (COUNT_BITS+1)'(r_slope_margin)));
        for (int s = 0; s < SLOTS; s++) begin
            d   = r_s1_row[SLOT_BITS-1:0] - SLOT_BITS'(s);
            lag = (d == '0) ? DIST_BITS'(SLOTS) : DIST_BITS'(d);
            if ((lag <= DIST_BITS'({rch, 1'b0})) && (lag != DIST_BITS'(rch))) begin
                if ({1'b0, center} < ({1'b0, r_rd[s]} + (COUNT_BITS+1)'(r_slope_margin))) begin
                    keep = 1'b0;
                end
            end
        end
    end

    // up to two results per transaction, inner decision first
    assign any_res  = has_a | has_b;
    assign sel_a    = has_a & ~r_s1_phase;
    assign two_left = sel_a & has_b;
    assign out_ok   = ~r_o_valid | o_res.ready;
    assign s1_emit  = r_s1_valid & any_res & out_ok;
    assign s1_pop   = r_s1_valid & (~any_res | (out_ok & ~two_left));
    assign i_cell.ready = ~r_s1_valid | s1_pop;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_phase = r_s1_phase;
        if (in_acc) begin
            n_s1_valid = 1'b1;
            n_s1_phase = 1'b0;
        end else if (s1_pop) begin
            n_s1_valid = 1'b0;
        end else if (s1_emit) begin
            n_s1_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s1_phase <= n_s1_phase;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_emit) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_o_col <= r_s1_col;
            if (sel_a) begin
                r_o_row   <= r0;
                r_o_count <= keep ? center : '0;
                r_o_last  <= ~has_b;
            end else begin
                r_o_row   <= r_s1_row;
                r_o_count <= r_s1_cnt;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.out_row     = r_o_row;
    assign o_res.out_col     = r_o_col;
    assign o_res.out_count   = r_o_count;
    assign o_res.last_of_run = r_o_last;

endmodule

[rtl/vlpf_checker.sv]
`timescale 1ns / 1ps

module vlpf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // reset empties the output
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // second result of a pair follows the first without a gap
    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last)
        else $error("second result of a pair missing");

    // no new cell while the first of a pair is stuck
    a_pair_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready && !i_out_last |-> !i_in_ready)
        else $error("input taken while pair pending");

endmodule

bind vertical_local_peak_filter vlpf_checker u_vlpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_last  (o_res.last_of_run)
);

[sim/vertical_local_peak_filter_test.sv]
`timescale 1ns / 1ps

module vertical_local_peak_filter_test;
    import vlpf_pkg::*;

    // drain wait after the last expected result: two pipeline registers plus slack
    localparam int DRAIN_CYCLES = 8;
    // long receiver hold-off, long enough to fill the pipe and stall i_cell
    localparam int HOLD_CYCLES  = 400;
    // cycles with no transaction on either side before the run is abandoned
    localparam int STALL_LIMIT  = 4000;
    // stimulus stops once this many cells have been accepted
    localparam int TARGET_CELLS = 1850;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        t_count              count;
        logic                last;
    } t_cell_result;

    logic i_clk;
    logic i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    vlpf_in_if  cell_if ();
    vlpf_out_if res_if ();

    vertical_local_peak_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block: line buffer, raster position and register values
    t_count                 line_buf [SLOTS][MAX_WIDTH];
    int unsigned            row_pos;
    int unsigned            col_pos;
    logic [DIM_BITS-1:0]    cfg_width;
    logic [DIM_BITS-1:0]    cfg_height;
    logic [REACH_BITS-1:0]  cfg_reach;
    logic [MARGIN_BITS-1:0] cfg_margin;

    // decisions still owed by the block, oldest first
    t_cell_result decided_cells [$];

    int unsigned errors;
    int unsigned cells_sent;
    int unsigned stall_cycles;
    bit          steady;        // both sides run with no idling while set
    int unsigned hold_asked;    // hold-off requests for the receiver
    int unsigned hold_served;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // register value as the block reads it: zero is one, above the limit is the limit
    function automatic int unsigned bound(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_cell_result make_result(input int unsigned r, input int unsigned c,
                                                 input t_count cnt);
        t_cell_result x;
        x.row   = r[ROW_BITS-1:0];
        x.col   = c[COL_BITS-1:0];
        x.count = cnt;
        x.last  = 1'b0;
        return x;
    endfunction

    // advance the shadow by one accepted cell and queue the decisions it causes
    task automatic apply_peak_rule(input t_count cnt, input logic fs);
        int unsigned  w, h, rch, r, c, r0, k, above, below;
        t_count       center;
        bit           keep;
        t_cell_result outs [2];
        int           n;
        w   = bound(cfg_width, MAX_WIDTH);
        h   = bound(cfg_height, MAX_HEIGHT);
        rch = bound(cfg_reach, MAX_REACH);
        n   = 0;
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos % MAX_WIDTH;
        // the cell reach rows up is now fully surrounded: decide it
        if (r >= 2 * rch && r < h) begin
            r0     = r - rch;
            center = line_buf[r0 % SLOTS][c];
            keep   = (center != 0);
            for (k = 1; k <= rch; k++) begin
                above = line_buf[(r0 - k) % SLOTS][c];
                below = (k == rch) ? cnt : line_buf[(r0 + k) % SLOTS][c];
                // sums in 32 bits, no wrap
                if (center < above + cfg_margin || center < below + cfg_margin) begin
                    keep = 1'b0;
                end
            end
            outs[n] = make_result(r0, c, keep ? center : t_count'(0));
            n++;
        end
        // top and bottom border rows (and whole short frames) pass at once
        if (r < rch || r + rch >= h) begin
            outs[n] = make_result(r, c, cnt);
            n++;
        end
        line_buf[r % SLOTS][c] = cnt;
        if (n > 0) begin
            outs[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            decided_cells = {decided_cells, outs[i]};
        end
        // raster advance; a position past a shrunk bound still wraps here
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endtask

    // offer one cell, with random idle cycles in front, and wait for the transaction
    task automatic send_cell(input t_count cnt, input logic fs);
        if (!steady) begin
            while ($urandom_range(99) < 30) begin
                cell_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        cell_if.valid       <= 1'b1;
        cell_if.cell_count  <= cnt;
        cell_if.frame_start <= fs;
        @(posedge i_clk);
        while (!cell_if.ready) @(posedge i_clk);
        cells_sent++;
        apply_peak_rule(cnt, fs);
    endtask

    // drop valid, wait for every owed decision, then let the pipe empty
    task automatic settle();
        cell_if.valid <= 1'b0;
        while (decided_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, register taken at the following edge
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GRID_COLS:    cfg_width  = val[DIM_BITS-1:0];
            REG_GRID_ROWS:    cfg_height = val[DIM_BITS-1:0];
            REG_WINDOW_REACH: cfg_reach  = val[REACH_BITS-1:0];
            REG_SLOPE_MARGIN: cfg_margin = val[MARGIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned rch, input int unsigned margin);
        write_reg(REG_GRID_COLS, w);
        write_reg(REG_GRID_ROWS, h);
        write_reg(REG_WINDOW_REACH, rch);
        write_reg(REG_SLOPE_MARGIN, margin);
    endtask

    // mostly low background with some peaks, plus the count extremes
    function automatic t_count pick_count();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_count'($urandom_range(0, 65535));
            4, 5, 6: return t_count'($urandom_range(40, 200));
            default: return t_count'($urandom_range(0, 30));
        endcase
    endfunction

    // reset register values, a few top border cells
    task automatic test_reset_defaults();
        send_cell(16'hFFFF, 1'b1);
        send_cell(16'h0000, 1'b0);
        settle();
    endtask

    // single-column frames: ties at margin zero, margin at its maximum,
    // zero center, frame wrap without frame_start
    task automatic test_column_peaks();
        configure(1, 5, 0, 0);
        send_cell(16'h0000, 1'b1);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'h0000, 1'b0);
        settle();
        configure(1, 3, 1, 16'hFFFF);
        send_cell(16'h0000, 1'b1);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'h0000, 1'b0);
        settle();
        // position wrapped to row 0 on its own
        write_reg(REG_SLOPE_MARGIN, 0);
        send_cell(16'h0000, 1'b0);
        send_cell(16'h0000, 1'b0);
        send_cell(16'h0000, 1'b0);
        settle();
    endtask

    // short frame passes whole; reach above the limit; restart mid-frame
    task automatic test_short_frame_restart();
        configure(1, 4, 2, 10);
        send_cell(16'd5, 1'b1);
        send_cell(16'd100, 1'b0);
        send_cell(16'd5, 1'b0);
        send_cell(16'd7, 1'b0);
        settle();
        configure(1, 9, 7, 10);
        send_cell(16'd9, 1'b1);
        // frame_start again after one cell: position goes back to the top
        send_cell(16'd1, 1'b1);
        send_cell(16'd2, 1'b0);
        send_cell(16'd3, 1'b0);
        send_cell(16'd4, 1'b0);
        send_cell(16'd500, 1'b0);
        send_cell(16'd4, 1'b0);
        send_cell(16'd3, 1'b0);
        send_cell(16'd2, 1'b0);
        send_cell(16'd1, 1'b0);
        settle();
    endtask

    // width and height lowered mid-frame while the position lies past the new bound
    task automatic test_shrunk_geometry();
        configure(6, 10, 2, 8);
        send_cell(pick_count(), 1'b1);
        repeat (40) send_cell(pick_count(), 1'b0);
        settle();
        // now at row 6, column 5; width 3 leaves column 5 out of range
        write_reg(REG_GRID_COLS, 3);
        repeat (4) send_cell(pick_count(), 1'b0);
        settle();
        // now at row 8; height 7 leaves this row out of range
        write_reg(REG_GRID_ROWS, 7);
        repeat (24) send_cell(pick_count(), 1'b0);
        settle();
    endtask

    // receiver holds off for a long stretch while cells keep coming
    task automatic test_output_backpressure();
        configure(8, 12, 2, 5);
        hold_asked++;
        send_cell(pick_count(), 1'b1);
        repeat (95) send_cell(pick_count(), 1'b0);
        settle();
    endtask

    // random geometry per phase, mostly whole frames, some restarts and cut frames
    task automatic test_random_frames();
        int unsigned raw_w, raw_h, raw_r, raw_m, w, h, frames, phase;
        logic        fs;
        phase = 0;
        while (cells_sent < TARGET_CELLS) begin
            steady = (phase >= 4 && phase < 9);
            case ($urandom_range(9))
                0: begin
                    raw_w = $urandom_range(1) ? 64 : 127;
                    raw_h = $urandom_range(1, 4);
                end
                1: begin
                    raw_w = $urandom_range(0, 2);
                    case ($urandom_range(2))
                        0:       raw_h = 64;
                        1:       raw_h = 100;
                        default: raw_h = 0;
                    endcase
                end
                default: begin
                    raw_w = $urandom_range(1, 8);
                    raw_h = $urandom_range(1, 16);
                end
            endcase
            raw_r = $urandom_range(0, 7);
            case ($urandom_range(9))
                0:       raw_m = 0;
                1:       raw_m = 16'hFFFF;
                2:       raw_m = $urandom_range(0, 65535);
                default: raw_m = $urandom_range(1, 20);
            endcase
            configure(raw_w, raw_h, raw_r, raw_m);
            w      = bound(raw_w, MAX_WIDTH);
            h      = bound(raw_h, MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                for (int i = 0; i < w * h && cells_sent < TARGET_CELLS; i++) begin
                    // an occasional frame is cut short
                    if (i > 0 && $urandom_range(199) == 0) break;
                    if (i == 0) begin
                        fs = (f == 0) || $urandom_range(1);
                    end else begin
                        fs = ($urandom_range(99) < 2);
                    end
                    send_cell(pick_count(), fs);
                end
            end
            settle();
            phase++;
        end
        steady = 1'b0;
    endtask

    // receiver: random ready, hold-off on request, compare each result in order
    initial begin : result_check
        t_cell_result got;
        t_cell_result want;
        int unsigned  hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.row   = res_if.out_row;
                got.col   = res_if.out_col;
                got.count = res_if.out_count;
                got.last  = res_if.last_of_run;
                if (decided_cells.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing owed: row %0d col %0d count %0d last %0b",
                             $time, got.row, got.col, got.count, got.last);
                end else begin
                    want = decided_cells.pop_front();
                    if (got.row !== want.row) begin
                        errors++;
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, want.row, got.row);
                    end
                    if (got.col !== want.col) begin
                        errors++;
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, want.col, got.col);
                    end
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t: out_count expected %0d actual %0d (row %0d col %0d)",
                                 $time, want.count, got.count, want.row, want.col);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (steady) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transaction for %0d cycles, %0d results owed",
                         $time, stall_cycles, decided_cells.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        errors       = 0;
        cells_sent   = 0;
        stall_cycles = 0;
        steady       = 1'b0;
        hold_asked   = 0;
        hold_served  = 0;
        row_pos      = 0;
        col_pos      = 0;
        cfg_width    = RST_GRID_COLS;
        cfg_height   = RST_GRID_ROWS;
        cfg_reach    = RST_WINDOW_REACH;
        cfg_margin   = RST_SLOPE_MARGIN;
        i_rst_n             <= 1'b0;
        cell_if.valid       <= 1'b0;
        cell_if.cell_count  <= '0;
        cell_if.frame_start <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_column_peaks();
        test_short_frame_restart();
        test_shrunk_geometry();
        test_output_backpressure();
        test_random_frames();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
